>>> rtl/lfu_pkg.sv
// shared constants, types and helper functions of the lfu cache replacement core
// no dependencies; imported by lfu_scan and lfu_cache_replacement_core

package lfu_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CAP_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [DATA_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NO_VALUE  = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    // one slot as stored in the entry memory
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             clear;
        logic             sample;
        logic [IDX_W-1:0] idx;
        logic             valid;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [DATA_W-1:0] hit_value;
        logic [DATA_W-1:0] hit_count;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
        logic [IDX_W-1:0]  victim_idx;
    } t_scan_res;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        return (v >= SAT_MAX) ? SAT_MAX : v + 32'd1;
    endfunction

endpackage

>>> rtl/lfu_cache_replacement_core.sv
// lfu key-value store: each request scans the active slots (slot limit, at most 16), reading one
// entry per cycle from the ram, then passes the write-back and done states into the result register
// with zero active slots the scan and write-back are skipped; one request is in flight at a time
// reset (synchronous, active low) clears all valid bits, the time counter and the handshakes,
// and sets the slot limit to 16; no clearing pass, the core takes requests right after reset
// depends on lfu_pkg, lfu_ram, lfu_scan

module lfu_cache_replacement_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slot limit register
    input  logic                      i_cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wr_data,
    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]                s_axis_tuser,   // [0] op (0 get, 1 put)
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,   // [31:0] read_value
    output logic [0:0]                m_axis_tuser    // [0] hit
);
    import lfu_pkg::*;

    // control state
    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [DATA_W-1:0] r_time;
    logic [CAPACITY-1:0] r_valid;
    logic              r_rd_pend;
    logic              r_out_valid;

    // per-request payload
    logic              r_op;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;
    logic [CAP_W-1:0]  r_cap;
    logic [CAP_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_rd_pidx;
    logic              r_res_hit;
    logic [DATA_W-1:0] r_res_val;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_val;

    logic [CAP_W-1:0]  cap_sel;
    logic              in_xfer;
    logic              rd_issue;
    logic              out_free;
    t_scan_ctl         scan_ctl;
    t_scan_res         scan_res;
    t_entry            rd_entry;
    t_entry            wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  wr_idx;

    // slot limit above the physical size acts as the physical size
    always_comb begin
        cap_sel = (32'(r_cfg) > 32'(CAPACITY)) ? CAP_W'(CAPACITY) : CAP_W'(r_cfg);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign rd_entry      = t_entry'(ram_rdata);

    // scan reads one slot per cycle; the registered read data comes back in the next cycle
    always_comb begin
        rd_issue        = (r_state == S_SCAN) && (r_rd_idx < r_cap);
        scan_ctl.clear  = in_xfer;
        scan_ctl.sample = r_rd_pend;
        scan_ctl.idx    = r_rd_pidx;
        scan_ctl.valid  = r_valid[r_rd_pidx];
    end

    // write-back: refresh a hit; a put miss fills the first empty slot, else the victim
    always_comb begin
        if (scan_res.hit) begin
            wr_idx = scan_res.hit_idx;
        end else if (scan_res.free) begin
            wr_idx = scan_res.free_idx;
        end else begin
            wr_idx = scan_res.victim_idx;
        end
        wr_entry.key   = r_key;
        wr_entry.value = (scan_res.hit && (r_op == OP_GET)) ? scan_res.hit_value : r_value;
        wr_entry.count = scan_res.hit ? sat_inc(scan_res.hit_count) : 32'd1;
        wr_entry.stamp = r_time;
        ram_we = (r_state == S_WRITE) && (scan_res.hit || (r_op == OP_PUT));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (cap_sel == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd_issue && !r_rd_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_time      <= '0;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= rd_issue;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            // every request advances time, even with no slots in use
            if (in_xfer) begin
                r_time <= sat_inc(r_time);
            end
            if ((r_state == S_WRITE) && !scan_res.hit && (r_op == OP_PUT)) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op      <= s_axis_tuser[0];
            r_key     <= s_axis_tdata[31:0];
            r_value   <= s_axis_tdata[63:32];
            r_cap     <= cap_sel;
            r_rd_idx  <= '0;
            r_res_hit <= 1'b0;
            r_res_val <= NO_VALUE;
        end else if (rd_issue) begin
            r_rd_idx <= r_rd_idx + CAP_W'(1);
        end
        if (rd_issue) begin
            r_rd_pidx <= r_rd_idx[IDX_W-1:0];
        end
        if (r_state == S_WRITE) begin
            r_res_hit <= scan_res.hit;
            r_res_val <= (scan_res.hit && (r_op == OP_GET)) ? scan_res.hit_value : NO_VALUE;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    // entry store; the write lands before the next request can read, so no forwarding
    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    lfu_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (rd_entry),
        .i_key   (r_key),
        .o_res   (scan_res)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_val;
    assign m_axis_tuser[0] = r_out_hit;

endmodule

>>> rtl/lfu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used for the slot entry store

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lfu_scan.sv
// scan accumulator: key match, first empty slot and eviction victim over one pass
// depends on lfu_pkg

module lfu_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfu_pkg::t_scan_ctl i_ctl,
    input  lfu_pkg::t_entry    i_entry,
    input  logic [31:0]        i_key,
    output lfu_pkg::t_scan_res o_res
);
    import lfu_pkg::*;

    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [DATA_W-1:0] r_hit_value;
    logic [DATA_W-1:0] r_hit_count;
    logic              r_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_best_set;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DATA_W-1:0] r_best_count;
    logic [DATA_W-1:0] r_best_stamp;

    logic match;
    logic take_free;
    logic better;

    always_comb begin
        match     = i_ctl.sample && i_ctl.valid && !r_hit && (i_entry.key == i_key);
        take_free = i_ctl.sample && !i_ctl.valid && !r_free;
        // strict compare keeps the lowest index on a full tie
        better    = i_ctl.sample && i_ctl.valid &&
                    (!r_best_set ||
                     (i_entry.count < r_best_count) ||
                     ((i_entry.count == r_best_count) && (i_entry.stamp < r_best_stamp)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_best_set <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_best_set <= 1'b0;
        end else begin
            if (match) begin
                r_hit <= 1'b1;
            end
            if (take_free) begin
                r_free <= 1'b1;
            end
            if (better) begin
                r_best_set <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            r_hit_idx   <= i_ctl.idx;
            r_hit_value <= i_entry.value;
            r_hit_count <= i_entry.count;
        end
        if (take_free) begin
            r_free_idx <= i_ctl.idx;
        end
        if (better) begin
            r_best_idx   <= i_ctl.idx;
            r_best_count <= i_entry.count;
            r_best_stamp <= i_entry.stamp;
        end
    end

    always_comb begin
        o_res.hit        = r_hit;
        o_res.hit_idx    = r_hit_idx;
        o_res.hit_value  = r_hit_value;
        o_res.hit_count  = r_hit_count;
        o_res.free       = r_free;
        o_res.free_idx   = r_free_idx;
        o_res.victim_idx = r_best_idx;
    end

endmodule

>>> rtl/lfu_checker.sv
// port-level checks of the lfu cache replacement core
// bound to lfu_cache_replacement_core; no package dependency

module lfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its contents
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // a miss always reports the empty marker
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'hFFFF_FFFF)
        else $error("miss with a read value");

endmodule

bind lfu_cache_replacement_core lfu_checker u_lfu_checker (.*);

>>> tb/sv/lfu_cache_replacement_checker.sv
// scoreboard for lfu_cache_replacement_core: mirrors the keyed store and checks every answer
// depends on lfu_pkg for the slot count, widths, op codes and the no-value constant

module lfu_cache_replacement_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                      i_req_tvalid,
    input  logic                      i_req_tready,
    input  logic [63:0]               i_req_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]                i_req_tuser,   // [0] op
    input  logic                      i_rsp_tvalid,
    input  logic                      i_rsp_tready,
    input  logic [31:0]               i_rsp_tdata,   // [31:0] read_value
    input  logic [0:0]                i_rsp_tuser,   // [0] hit
    output int                        o_mismatches,
    output int                        o_results_seen,
    output int                        o_outstanding
);
    import lfu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } t_lookup_answer;

    // mirrored store
    logic [CFG_W-1:0]  slot_limit;
    logic              held       [CAPACITY];
    logic [DATA_W-1:0] held_key   [CAPACITY];
    logic [DATA_W-1:0] held_value [CAPACITY];
    logic [DATA_W-1:0] use_count  [CAPACITY];
    logic [DATA_W-1:0] last_touch [CAPACITY];
    logic [DATA_W-1:0] request_clock;

    t_lookup_answer predicted_answers[$];

    function automatic logic [DATA_W-1:0] bump_saturated(input logic [DATA_W-1:0] v);
        return (v >= SAT_MAX) ? SAT_MAX : v + 1'b1;
    endfunction

    // one get or put against the mirrored store
    function automatic t_lookup_answer serve_request(input logic op,
                                                     input logic [DATA_W-1:0] key,
                                                     input logic [DATA_W-1:0] value);
        t_lookup_answer answer;
        int active;
        int slot;
        int i;
        answer.hit        = 1'b0;
        answer.read_value = NO_VALUE;
        active = (slot_limit > CAPACITY) ? CAPACITY : int'(slot_limit);
        request_clock = bump_saturated(request_clock);
        slot = -1;
        for (i = 0; i < active; i++)
            if (slot < 0 && held[i] && held_key[i] == key) slot = i;
        if (slot >= 0) begin
            answer.hit       = 1'b1;
            use_count[slot]  = bump_saturated(use_count[slot]);
            last_touch[slot] = request_clock;
            if (op == OP_PUT) held_value[slot] = value;
            else answer.read_value = held_value[slot];
        end else if (op == OP_PUT && active > 0) begin
            // lowest free slot, else fewest uses, then oldest touch, then lowest index
            for (i = 0; i < active; i++)
                if (slot < 0 && !held[i]) slot = i;
            if (slot < 0) begin
                slot = 0;
                for (i = 1; i < active; i++)
                    if (use_count[i] < use_count[slot] ||
                        (use_count[i] == use_count[slot] && last_touch[i] < last_touch[slot]))
                        slot = i;
            end
            held[slot]       = 1'b1;
            held_key[slot]   = key;
            held_value[slot] = value;
            use_count[slot]  = 1;
            last_touch[slot] = request_clock;
        end
        return answer;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup_answer want;
        int i;
        if (!i_rst_n) begin
            slot_limit    = CFG_RESET;
            request_clock = '0;
            for (i = 0; i < CAPACITY; i++) held[i] = 1'b0;
            predicted_answers.delete();
            o_mismatches   = 0;
            o_results_seen = 0;
        end else begin
            if (i_cfg_wr_en) slot_limit = i_cfg_wr_data;
            if (i_rsp_tvalid && i_rsp_tready) begin
                o_results_seen++;
                if (predicted_answers.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("unexpected result: hit=%0b value=%h",
                                 i_rsp_tuser[0], i_rsp_tdata);
                end else begin
                    want = predicted_answers.pop_front();
                    if (want.hit !== i_rsp_tuser[0] || want.read_value !== i_rsp_tdata) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT)
                            $display("result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                                     o_results_seen, want.hit, want.read_value,
                                     i_rsp_tuser[0], i_rsp_tdata);
                    end
                end
            end
            if (i_req_tvalid && i_req_tready)
                predicted_answers.push_back(serve_request(i_req_tuser[0], i_req_tdata[31:0],
                                                          i_req_tdata[63:32]));
        end
        o_outstanding = predicted_answers.size();
    end

endmodule

>>> tb/sv/lfu_cache_replacement_core_tb.sv
// top of the lfu_cache_replacement_core testbench: clock, reset, request and result stimulus
// depends on lfu_pkg, lfu_cache_replacement_core and lfu_cache_replacement_checker

module lfu_cache_replacement_core_tb;
    import lfu_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int TIMEOUT_CYCLES = 200_000;
    // idle wait after draining, before a slot limit write and before the final report
    localparam int SETTLE_CYCLES  = 24;
    // long receiver hold-off, starts once this many results were taken
    localparam int HOLD_AT_RESULT = 200;
    localparam int HOLD_CYCLES    = 160;
    localparam int POOL_SIZE      = 24;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;   // [31:0] key, [63:32] value
    logic [0:0]        s_axis_tuser  = '0;   // [0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;         // [31:0] read_value
    logic [0:0]        m_axis_tuser;         // [0] hit

    int mismatches;
    int results_seen;
    int outstanding;
    int sent   = 0;
    int phases = 1;
    // set for the final phase: no idling on either side
    bit quiet_tail = 1'b0;

    // keys reused so that gets and puts hit; first four are the key extremes
    logic [DATA_W-1:0] key_pool [POOL_SIZE];

    lfu_cache_replacement_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lfu_cache_replacement_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_req_tvalid   (s_axis_tvalid),
        .i_req_tready   (s_axis_tready),
        .i_req_tdata    (s_axis_tdata),
        .i_req_tuser    (s_axis_tuser),
        .i_rsp_tvalid   (m_axis_tvalid),
        .i_rsp_tready   (m_axis_tready),
        .i_rsp_tdata    (m_axis_tdata),
        .i_rsp_tuser    (m_axis_tuser),
        .o_mismatches   (mismatches),
        .o_results_seen (results_seen),
        .o_outstanding  (outstanding)
    );

    initial begin : clock_gen
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    // one request transfer, with an optional idle burst in front
    task automatic send_request(input logic op, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= op;
        // transfer happens at the edge where tready was seen high
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // wait until every request has been answered
    task automatic drain_results();
        while (results_seen < sent) @(posedge i_clk);
    endtask

    // slot limit only changes with the block idle
    task automatic set_slot_limit(input logic [CFG_W-1:0] limit);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        phases++;
    endtask

    // directed opening at the reset slot limit of 16
    task automatic run_directed();
        int i;
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);              // get on an empty store
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);      // key and value extremes
        send_request(OP_PUT, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h0000_0000, 32'h0);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);              // hit whose value is all ones
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);      // put hit updates value
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(OP_GET, 32'h5555_5555, 32'h0);              // miss while slots are free
        // fill the remaining twelve slots, each with one use
        for (i = 0; i < 12; i++)
            send_request(OP_PUT, 32'h0000_1000 + i, $urandom);
        // store full: the oldest single-use entry goes
        send_request(OP_PUT, 32'hAAAA_AAAA, 32'h5A5A_A5A5);
        s_axis_tvalid <= 1'b0;
    endtask

    // random gets and puts, keys mostly from the first pool_n pool entries
    task automatic run_random(input int count, input int pool_n);
        int k;
        logic [DATA_W-1:0] key;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_n - 1)];
            else key = $urandom;
            send_request(($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET, key, $urandom);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // result side: random stall bursts plus one long hold-off that backs up the input
    initial begin : result_sink
        int  taken;
        bit  held_off;
        taken    = 0;
        held_off = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) taken++;
            if (!held_off && taken >= HOLD_AT_RESULT) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int i;
        for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h7FFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        // more keys than slots: steady eviction at full size
        run_random(120, 24);
        // shrink: upper slots keep their entries but drop out of view
        set_slot_limit(5'd3);
        run_random(80, 8);
        // storing disabled
        set_slot_limit(5'd0);
        run_random(30, 8);
        // single slot: every put miss evicts
        set_slot_limit(5'd1);
        run_random(60, 4);
        // largest register value acts as 16, hidden entries come back
        set_slot_limit(5'd31);
        run_random(100, 24);
        // many single-use ties broken by age
        set_slot_limit(5'd5);
        run_random(80, 10);
        set_slot_limit(5'd17);
        run_random(70, 20);
        // last stretch at full size without any idling
        set_slot_limit(5'd16);
        quiet_tail = 1'b1;
        run_random(120, 24);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over %0d slot-limit settings: zero, one, small, full, above",
                 sent, phases);
        $display("results checked %0d, mismatches %0d, still awaited %0d",
                 results_seen, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
